[design/lttf_pkg.sv]
// ---------------------------------------------------------------------------
// lttf_pkg: shared types and codes for the learnable transition table
// Operation and status codes, the scan packet and the slot write command.
// ---------------------------------------------------------------------------
package lttf_pkg;

  localparam int DATA_W = 16;
  localparam int PAGE_W = 8;
  localparam int KIND_W = 3;
  localparam int STAT_W = 3;
  localparam int USED_W = 7;

  localparam logic [USED_W-1:0] USED_MAX = 7'd127;
  localparam logic [PAGE_W-1:0] SEQ_LIMIT = 8'd128;
  localparam logic [PAGE_W-1:0] PAGE_NONE = 8'd0;

  // Operation kinds
  localparam logic [KIND_W-1:0] K_READ   = 3'd0;
  localparam logic [KIND_W-1:0] K_LEARN  = 3'd1;
  localparam logic [KIND_W-1:0] K_REMOVE = 3'd2;
  localparam logic [KIND_W-1:0] K_CLEAR  = 3'd3;
  localparam logic [KIND_W-1:0] K_COUNT  = 3'd4;

  // Result status codes
  localparam logic [STAT_W-1:0] ST_DONE    = 3'd0;
  localparam logic [STAT_W-1:0] ST_MISS    = 3'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY   = 3'd2;
  localparam logic [STAT_W-1:0] ST_EXISTS  = 3'd3;
  localparam logic [STAT_W-1:0] ST_FULL    = 3'd4;
  localparam logic [STAT_W-1:0] ST_NOCLEAR = 3'd5;

  // Query packet that walks the row of slot cells
  typedef struct packed {
    logic              active;
    logic [KIND_W-1:0] kind;
    logic [DATA_W-1:0] key;
    logic [DATA_W-1:0] fb;
    logic [DATA_W-1:0] nv;
    logic              seen;
    logic              hit;
    logic [DATA_W-1:0] hit_next;
    logic              free_found;
    logic              any;
    logic [USED_W-1:0] cnt;
  } pkt_t;

  // Slot write command, issued when a learn finishes its scan
  typedef struct packed {
    logic              en;
    logic [PAGE_W-1:0] tag;
    logic [DATA_W-1:0] fb;
    logic [DATA_W-1:0] key;
    logic [DATA_W-1:0] nxt;
  } wr_t;

endpackage

[design/learnable_transition_table_fsm.sv]
// ---------------------------------------------------------------------------
// learnable_transition_table_fsm: programmable transition-table state machine
// A row of slot cells holds the transitions; each operation walks the row.
// ---------------------------------------------------------------------------
// Usage:
//   Input transfers on s_tvalid/s_tready carry one operation: tuser holds the
//   kind (read, learn, remove, clear all, count), tdata the key and the value
//   to learn. Each operation gives exactly one output transfer on
//   m_tvalid/m_tready with the status, the output register and the slot count.
//   cfg_wr_en/cfg_wr_data set the page; write it only while idle.
//   Sequence: the accepted operation is loaded into the query packet register,
//   which feeds the row; each cell registers the packet and hands it on, and
//   when it leaves the last cell the result is registered and shown. Kinds
//   that need no table access (unknown kinds, and read/learn/remove on page
//   zero) answer on the next cycle. One operation at a time is handled, as
//   each must walk the cell row. A new input is taken in the cycle the
//   pending result is transferred.
//   Reset clears every slot tag, the output register and sets the page to 1.
//   When the receiver stalls, the result holds and no new input is taken.
// ---------------------------------------------------------------------------
module learnable_transition_table_fsm
  import lttf_pkg::*;
#(
  parameter int SLOTS = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data,     // page
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,         // [15:0] key, [31:16] next_value
  input  logic [2:0]  s_tuser,         // [2:0] kind
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata          // [2:0] status, [18:3] current_output,
                                       // [25:19] used_slots, [31:26] zero
);

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_RESP = 3'b100
  } state_t;

  state_t            state;
  state_t            state_next;
  logic [PAGE_W-1:0] page;
  logic [DATA_W-1:0] output_reg;
  logic [DATA_W-1:0] output_next;
  logic [STAT_W-1:0] res_status;
  logic [STAT_W-1:0] res_status_next;
  logic [USED_W-1:0] res_used;
  logic [USED_W-1:0] res_used_next;
  pkt_t              pkt0;
  pkt_t              pkt0_next;
  pkt_t              chain [SLOTS+1];
  logic [IW-1:0]     fidx  [SLOTS+1];
  pkt_t              fin;
  wr_t               wr;
  logic              accept;
  logic              done;
  logic              direct;
  logic              comb_mode;
  logic [DATA_W-1:0] page_ext;
  logic [KIND_W-1:0] in_kind;
  logic [DATA_W-1:0] in_key;
  logic [DATA_W-1:0] in_nv;

  assign in_kind   = s_tuser;
  assign in_key    = s_tdata[15:0];
  assign in_nv     = s_tdata[31:16];
  assign comb_mode = (page < SEQ_LIMIT);
  assign page_ext  = {{(DATA_W-PAGE_W){1'b0}}, page};

  assign s_tready = (state == S_IDLE) || ((state == S_RESP) && m_tready);
  assign m_tvalid = (state == S_RESP);
  assign m_tdata  = {6'b0, res_used, output_reg, res_status};
  assign accept   = s_tvalid && s_tready;

  assign fin  = chain[SLOTS];
  assign done = fin.active;

  // Kinds answered without walking the row
  assign direct = ((in_kind == K_READ || in_kind == K_LEARN || in_kind == K_REMOVE)
                   && page == PAGE_NONE)
                  || !(in_kind == K_READ || in_kind == K_LEARN || in_kind == K_REMOVE
                       || in_kind == K_CLEAR || in_kind == K_COUNT);

  // Row of slot cells
  assign chain[0] = pkt0;
  assign fidx[0]  = '0;

  for (genvar i = 0; i < SLOTS; i++) begin : g_cell
    lttf_cell #(
      .IW       (IW),
      .SLOT_IDX (i)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .page    (page),
      .pkt_in  (chain[i]),
      .idx_in  (fidx[i]),
      .wr      (wr),
      .wr_idx  (fidx[SLOTS]),
      .pkt_out (chain[i+1]),
      .idx_out (fidx[i+1])
    );
  end

  // Sequence operations and finish the scan
  always_comb begin
    state_next      = state;
    output_next     = output_reg;
    res_status_next = res_status;
    res_used_next   = res_used;
    pkt0_next       = '0;
    wr              = '0;
    case (state)
      S_IDLE: begin
      end
      S_SCAN: begin
        if (done) begin
          state_next    = S_RESP;
          res_used_next = '0;
          case (fin.kind)
            K_READ: begin
              if (fin.hit) begin
                res_status_next = ST_DONE;
                output_next     = fin.hit_next;
              end else begin
                res_status_next = fin.seen ? ST_MISS : ST_EMPTY;
              end
            end
            K_LEARN: begin
              if (fin.hit) begin
                res_status_next = ST_EXISTS;
              end else if (!fin.free_found) begin
                res_status_next = ST_FULL;
              end else begin
                res_status_next = ST_DONE;
                wr.en  = 1'b1;
                wr.tag = page;
                wr.fb  = comb_mode ? page_ext : output_reg;
                wr.key = fin.key;
                wr.nxt = fin.nv;
                if (comb_mode) begin
                  output_next = page_ext;
                end
              end
            end
            K_REMOVE: begin
              res_status_next = fin.hit ? ST_DONE : ST_MISS;
            end
            K_CLEAR: begin
              res_status_next = fin.any ? ST_DONE : ST_NOCLEAR;
            end
            K_COUNT: begin
              res_status_next = ST_DONE;
              res_used_next   = fin.cnt;
            end
            default: begin
              res_status_next = ST_DONE;
            end
          endcase
        end
      end
      S_RESP: begin
        if (m_tready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase

    // Launch a new operation
    if (accept) begin
      if (direct) begin
        state_next      = S_RESP;
        res_used_next   = '0;
        res_status_next = (page == PAGE_NONE && in_kind <= K_REMOVE) ? ST_EMPTY : ST_DONE;
      end else begin
        state_next       = S_SCAN;
        pkt0_next.active = 1'b1;
        pkt0_next.kind   = in_kind;
        pkt0_next.key    = in_key;
        pkt0_next.nv     = in_nv;
        pkt0_next.fb     = (in_kind == K_READ && comb_mode) ? page_ext : output_reg;
      end
    end
  end

  // Control and output registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      output_reg <= '0;
      page       <= 8'd1;
      pkt0       <= '0;
    end else begin
      state      <= state_next;
      output_reg <= output_next;
      pkt0       <= pkt0_next;
      if (cfg_wr_en) begin
        page <= cfg_wr_data;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    res_status <= res_status_next;
    res_used   <= res_used_next;
  end

  // The packet leaves the row only while a scan is outstanding
  a_done_in_scan: assert property (@(posedge clk) disable iff (rst)
    done |-> state == S_SCAN)
    else $error("packet left the cell row outside a scan");

  // A slot write happens only at the end of a learn scan
  a_wr_at_end: assert property (@(posedge clk) disable iff (rst)
    wr.en |-> (done && fin.kind == K_LEARN))
    else $error("slot write outside the end of a learn");

  // The output register moves only when a scan finishes
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    !done |=> $stable(output_reg))
    else $error("output register changed without a finished scan");

  // An accepted operation is either scanning or answering next cycle
  a_accept_next: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == S_SCAN || state == S_RESP))
    else $error("accepted operation was dropped");

endmodule

[design/lttf_cell.sv]
// ---------------------------------------------------------------------------
// lttf_cell: one slot of the transition table
// Holds one transition, checks the passing packet against it and hands the
// updated packet to the next cell in the next cycle.
// ---------------------------------------------------------------------------
module lttf_cell
  import lttf_pkg::*;
#(
  parameter int IW       = 6,
  parameter int SLOT_IDX = 0
) (
  input  logic              clk,
  input  logic              rst,
  input  logic [PAGE_W-1:0] page,
  input  pkt_t              pkt_in,
  input  logic [IW-1:0]     idx_in,
  input  wr_t               wr,
  input  logic [IW-1:0]     wr_idx,
  output pkt_t              pkt_out,
  output logic [IW-1:0]     idx_out
);

  localparam logic [IW-1:0] MY_IDX = IW'(SLOT_IDX);

  logic [PAGE_W-1:0] tag;
  logic [PAGE_W-1:0] tag_next;
  logic [DATA_W-1:0] fb;
  logic [DATA_W-1:0] key;
  logic [DATA_W-1:0] nxt;
  pkt_t              pkt_next;
  logic [IW-1:0]     idx_next;
  logic              used;
  logic              match;
  logic              wr_hit;

  assign used   = (tag != PAGE_NONE);
  assign match  = (tag == page) && (fb == pkt_in.fb) && (key == pkt_in.key);
  assign wr_hit = wr.en && (wr_idx == MY_IDX);

  // Compare this slot against the passing packet
  always_comb begin
    pkt_next = pkt_in;
    idx_next = idx_in;
    tag_next = tag;
    if (pkt_in.active) begin
      case (pkt_in.kind)
        K_READ, K_LEARN, K_REMOVE: begin
          if (tag == page) begin
            pkt_next.seen = 1'b1;
          end
          if (match && !pkt_in.hit) begin
            pkt_next.hit      = 1'b1;
            pkt_next.hit_next = nxt;
            if (pkt_in.kind == K_REMOVE) begin
              tag_next = PAGE_NONE;
            end
          end
          if (pkt_in.kind == K_LEARN && !used && !pkt_in.free_found) begin
            pkt_next.free_found = 1'b1;
            idx_next            = MY_IDX;
          end
        end
        K_CLEAR: begin
          if (used) begin
            pkt_next.any = 1'b1;
          end
          tag_next = PAGE_NONE;
        end
        K_COUNT: begin
          if (used && pkt_in.cnt != USED_MAX) begin
            pkt_next.cnt = pkt_in.cnt + 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
    if (wr_hit) begin
      tag_next = wr.tag;
    end
  end

  // Tag register, cleared at reset
  always_ff @(posedge clk) begin
    if (rst) begin
      tag <= PAGE_NONE;
    end else begin
      tag <= tag_next;
    end
  end

  // Slot payload, written by a learn
  always_ff @(posedge clk) begin
    if (wr_hit) begin
      fb  <= wr.fb;
      key <= wr.key;
      nxt <= wr.nxt;
    end
  end

  // Hand the packet to the neighbor
  always_ff @(posedge clk) begin
    if (rst) begin
      pkt_out <= '0;
    end else begin
      pkt_out <= pkt_next;
    end
    idx_out <= idx_next;
  end

endmodule

[verif/tb_learnable_transition_table_fsm.sv]
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_learnable_transition_table_fsm: self-checking bench for the slot table
// Streams read, learn, remove, clear-all and count operations into the block,
// predicts every result with a behavioral copy of the table, and compares
// status, output register and slot count on each output transfer. Pages in
// both combinational and sequential mode are exercised, including a full table.
// ---------------------------------------------------------------------------
module tb_learnable_transition_table_fsm;
  import lttf_pkg::*;

  localparam int N_SLOTS     = 64;
  localparam int CLK_HALF    = 2;
  localparam int RST_CYCLES  = 8;
  localparam int N_PHASES    = 10;
  localparam int OPS_PHASE   = 175;
  localparam int FILL_LEARNS = 70;
  localparam int LONG_HOLD   = 600;
  localparam int HOLD_PHASE  = 3;
  localparam int TIMEOUT_NS  = 5_000_000;
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [DATA_W-1:0] key;
    logic [DATA_W-1:0] nv;
  } op_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [DATA_W-1:0] out;
    logic [USED_W-1:0] used;
  } res_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_wr_en = 1'b0;
  logic [7:0]  cfg_wr_data = '0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;          // [15:0] key, [31:16] next_value
  logic [2:0]  s_tuser = '0;          // [2:0] kind
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;               // [2:0] status, [18:3] current_output,
                                      // [25:19] used_slots

  // Behavioral copy of the slot table and the output register
  logic [PAGE_W-1:0] slot_tag  [N_SLOTS];
  logic [DATA_W-1:0] slot_fb   [N_SLOTS];
  logic [DATA_W-1:0] slot_key  [N_SLOTS];
  logic [DATA_W-1:0] slot_next [N_SLOTS];
  logic [DATA_W-1:0] fsm_out = '0;
  logic [PAGE_W-1:0] cur_page = 8'd1;

  op_t  pending_ops[$];
  res_t expected_results[$];
  op_t  bus_op;

  logic [DATA_W-1:0] key_pool   [6];
  logic [DATA_W-1:0] value_pool [5];

  bit idle_on = 1'b1;
  bit hold_request = 1'b0;
  bit sink_hold = 1'b0;
  int src_gap = 0;
  int sink_gap = 0;
  int items_sent = 0;
  int results_seen = 0;
  int mismatches = 0;
  int pages_used = 1;
  int status_tally [8];

  learnable_transition_table_fsm #(.SLOTS(N_SLOTS)) dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata)
  );

  always #(CLK_HALF) clk = ~clk;

  // First slot of the current page with this feedback and key, or -1
  function automatic int find_entry(logic [DATA_W-1:0] fb, logic [DATA_W-1:0] key);
    for (int i = 0; i < N_SLOTS; i++) begin
      if (slot_tag[i] == cur_page && slot_fb[i] == fb && slot_key[i] == key) return i;
    end
    return -1;
  endfunction

  // Apply one operation to the table copy and return the result it gives
  function automatic res_t step_table(op_t op);
    res_t r;
    int idx;
    logic seen;
    logic [DATA_W-1:0] want_fb;
    r = '0;
    idx = -1;
    seen = 1'b0;
    case (op.kind)
      K_READ: begin
        want_fb = (cur_page < SEQ_LIMIT) ? DATA_W'(cur_page) : fsm_out;
        for (int i = 0; i < N_SLOTS; i++) begin
          if (idx < 0 && slot_tag[i] == cur_page) begin
            seen = 1'b1;
            if (slot_fb[i] == want_fb && slot_key[i] == op.key) idx = i;
          end
        end
        if (idx >= 0) begin
          fsm_out = slot_next[idx];
          r.status = ST_DONE;
        end else begin
          r.status = seen ? ST_MISS : ST_EMPTY;
        end
      end
      K_LEARN: begin
        if (find_entry(fsm_out, op.key) >= 0) begin
          r.status = ST_EXISTS;
        end else begin
          for (int i = 0; i < N_SLOTS; i++) begin
            if (idx < 0 && slot_tag[i] == PAGE_NONE) idx = i;
          end
          if (idx < 0) begin
            r.status = ST_FULL;
          end else begin
            // combinational pages feed back the page itself
            if (cur_page < SEQ_LIMIT) fsm_out = DATA_W'(cur_page);
            slot_tag[idx]  = cur_page;
            slot_fb[idx]   = fsm_out;
            slot_key[idx]  = op.key;
            slot_next[idx] = op.nv;
            r.status = ST_DONE;
          end
        end
      end
      K_REMOVE: begin
        idx = find_entry(fsm_out, op.key);
        if (idx >= 0) begin
          slot_tag[idx] = PAGE_NONE;
          r.status = ST_DONE;
        end else begin
          r.status = ST_MISS;
        end
      end
      K_CLEAR: begin
        for (int i = 0; i < N_SLOTS; i++) begin
          if (slot_tag[i] != PAGE_NONE) seen = 1'b1;
          slot_tag[i] = PAGE_NONE;
        end
        r.status = seen ? ST_DONE : ST_NOCLEAR;
      end
      K_COUNT: begin
        for (int i = 0; i < N_SLOTS; i++) begin
          if (slot_tag[i] != PAGE_NONE && r.used < USED_MAX) r.used = r.used + 1'b1;
        end
        r.status = ST_DONE;
      end
      default: r.status = ST_DONE;
    endcase
    r.out = fsm_out;
    status_tally[r.status]++;
    return r;
  endfunction

  // Compare one output transfer with the oldest expectation
  task automatic check_result(logic [31:0] word);
    res_t got;
    res_t want;
    got.status = word[2:0];
    got.out    = word[18:3];
    got.used   = word[25:19];
    results_seen++;
    if (expected_results.size() == 0) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("[%0t] unexpected result: status %0d out %h used %0d",
                 $realtime, got.status, got.out, got.used);
    end else begin
      want = expected_results.pop_front();
      if (got.status !== want.status || got.out !== want.out || got.used !== want.used) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("[%0t] result %0d wrong: status %0d/%0d out %h/%h used %0d/%0d (exp/got)",
                   $realtime, results_seen, want.status, got.status, want.out, got.out,
                   want.used, got.used);
      end
    end
  endtask

  task automatic queue_op(logic [KIND_W-1:0] kind, logic [DATA_W-1:0] key,
                          logic [DATA_W-1:0] nv);
    op_t op;
    op.kind = kind;
    op.key  = key;
    op.nv   = nv;
    pending_ops.push_back(op);
  endtask

  // Pause the sender until every result is back, then write the page
  task automatic set_page_when_idle(logic [PAGE_W-1:0] p);
    while (pending_ops.size() != 0 || expected_results.size() != 0 || s_tvalid)
      @(negedge clk);
    repeat (4) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= p;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    cur_page = p;
    pages_used++;
  endtask

  // Small pools make reads hit, learns collide and removes find their slot
  task automatic refresh_pools();
    logic [DATA_W-1:0] v;
    for (int i = 0; i < 6; i++) begin
      case ($urandom_range(0, 5))
        0: v = '0;
        1: v = '1;
        default: v = DATA_W'($urandom);
      endcase
      key_pool[i] = v;
    end
    value_pool[0] = DATA_W'(cur_page);
    value_pool[1] = fsm_out;
    for (int i = 2; i < 5; i++) value_pool[i] = DATA_W'($urandom);
  endtask

  task automatic queue_random_ops(int count);
    int pick;
    logic [DATA_W-1:0] key;
    logic [DATA_W-1:0] nv;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      key  = ($urandom_range(0, 9) == 0) ? DATA_W'($urandom) : key_pool[$urandom_range(0, 5)];
      nv   = ($urandom_range(0, 9) == 0) ? DATA_W'($urandom) : value_pool[$urandom_range(0, 4)];
      if (pick < 40)      queue_op(K_READ, key, nv);
      else if (pick < 64) queue_op(K_LEARN, key, nv);
      else if (pick < 78) queue_op(K_REMOVE, key, nv);
      else if (pick < 88) queue_op(K_COUNT, key, nv);
      else if (pick < 90) queue_op(K_CLEAR, key, nv);
      else queue_op(KIND_W'($urandom_range(0, 7)), DATA_W'($urandom), DATA_W'($urandom));
    end
  endtask

  // Fill every slot, overrun it, then free one and refill it
  task automatic fill_table();
    logic [DATA_W-1:0] base;
    base = DATA_W'($urandom);
    queue_op(K_CLEAR, base, '0);
    for (int i = 0; i < FILL_LEARNS; i++)
      queue_op(K_LEARN, base + DATA_W'(i), value_pool[i % 5]);
    queue_op(K_COUNT, '0, '0);
    queue_op(K_READ, base + 16'd3, '0);
    queue_op(K_REMOVE, base + 16'd10, '0);
    queue_op(K_REMOVE, base + 16'd10, '0);
    queue_op(K_LEARN, base - 16'd1, value_pool[2]);
    queue_op(K_LEARN, base - 16'd2, value_pool[3]);
    queue_op(K_COUNT, '0, '0);
  endtask

  // Drive operations: hold the current transfer until it is taken
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      src_gap  <= 0;
    end else begin
      if (s_tvalid && s_tready) begin
        expected_results.push_back(step_table(bus_op));
        items_sent++;
      end
      if (!s_tvalid || s_tready) begin
        if (src_gap != 0) begin
          src_gap  <= src_gap - 1;
          s_tvalid <= 1'b0;
        end else if (idle_on && pending_ops.size() != 0 && $urandom_range(0, 7) == 0) begin
          src_gap  <= $urandom_range(0, 16);
          s_tvalid <= 1'b0;
        end else if (pending_ops.size() != 0) begin
          bus_op = pending_ops.pop_front();
          s_tdata  <= {bus_op.nv, bus_op.key};
          s_tuser  <= bus_op.kind;
          s_tvalid <= 1'b1;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Take results and throttle the receiver
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      sink_gap <= 0;
    end else begin
      if (m_tvalid && m_tready) check_result(m_tdata);
      if (sink_hold) begin
        m_tready <= 1'b0;
      end else if (sink_gap != 0) begin
        sink_gap <= sink_gap - 1;
        m_tready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        sink_gap <= $urandom_range(0, 16);
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Long receiver stall so the block backs up and stalls its input
  initial begin
    wait (hold_request);
    @(posedge clk);
    sink_hold <= 1'b1;
    repeat (LONG_HOLD) @(posedge clk);
    sink_hold <= 1'b0;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("Mismatches found");
    $finish;
  end

  initial begin
    int page_plan [N_PHASES];
    logic [PAGE_W-1:0] next_page;
    page_plan = '{255, 1, 128, 127, -1, 255, -1, 1, -1, 128};
    for (int i = 0; i < N_SLOTS; i++) begin
      slot_tag[i]  = PAGE_NONE;
      slot_fb[i]   = '0;
      slot_key[i]  = '0;
      slot_next[i] = '0;
    end
    repeat (RST_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // Combinational page from reset: empty page, duplicate learn, hits and misses
    queue_op(K_READ,   16'h0000, 16'h0000);
    queue_op(K_COUNT,  16'h0000, 16'h0000);
    queue_op(K_LEARN,  16'h0000, 16'hFFFF);
    queue_op(K_LEARN,  16'hFFFF, 16'h0000);
    queue_op(K_LEARN,  16'h0000, 16'h1234);
    queue_op(K_REMOVE, 16'hFFFF, 16'h0000);
    queue_op(K_REMOVE, 16'hFFFF, 16'h0000);
    queue_op(K_READ,   16'hFFFF, 16'h0000);
    queue_op(K_READ,   16'h0000, 16'h0000);
    queue_op(K_COUNT,  16'h0000, 16'h0000);
    queue_op(K_CLEAR,  16'h0000, 16'h0000);
    queue_op(K_CLEAR,  16'h0000, 16'h0000);

    // Sequential page: chained transitions keyed on the output register
    set_page_when_idle(8'd255);
    queue_op(K_LEARN,  16'hA5A5, 16'h00FF);
    queue_op(K_READ,   16'hA5A5, 16'h0000);
    queue_op(K_READ,   16'hA5A5, 16'h0000);
    queue_op(K_LEARN,  16'hA5A5, 16'hFFFF);
    queue_op(K_READ,   16'hA5A5, 16'h0000);
    queue_op(K_LEARN,  16'hA5A5, 16'h0000);
    queue_op(K_REMOVE, 16'hA5A5, 16'h0000);
    queue_op(K_COUNT,  16'h0000, 16'h0000);
    queue_op(K_READ,   16'h5A5A, 16'h0000);
    set_page_when_idle(SEQ_LIMIT);
    queue_op(K_READ,   16'hA5A5, 16'h0000);

    // Random phases, one page setting each; the last ones run without idling
    for (int ph = 0; ph < N_PHASES; ph++) begin
      next_page = (page_plan[ph] < 0) ? PAGE_W'($urandom_range(1, 255)) : PAGE_W'(page_plan[ph]);
      set_page_when_idle(next_page);
      idle_on = (ph < N_PHASES - 2);
      refresh_pools();
      if (ph == 0) fill_table();
      queue_random_ops(OPS_PHASE);
      if (ph == HOLD_PHASE) hold_request = 1'b1;
    end

    // Drain, then let the block settle before judging
    while (pending_ops.size() != 0 || expected_results.size() != 0 || s_tvalid)
      @(negedge clk);
    repeat (N_SLOTS + 8) @(posedge clk);

    $display("Checked %0d results for %0d operations over %0d page settings.",
             results_seen, items_sent, pages_used);
    $display("Status mix done/miss/empty/exists/full/nothing-cleared: %0d/%0d/%0d/%0d/%0d/%0d",
             status_tally[ST_DONE], status_tally[ST_MISS], status_tally[ST_EMPTY],
             status_tally[ST_EXISTS], status_tally[ST_FULL], status_tally[ST_NOCLEAR]);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
